[src/wbs_pkg.sv]
// Shared types, constants and codes for the word break segmenter.
package wbs_pkg;

  localparam int DICT_WORDS   = 16;
  localparam int MAX_WORD_LEN = 16;

  localparam int SLOT_IW = (DICT_WORDS > 1) ? $clog2(DICT_WORDS) : 1;
  localparam int POS_IW  = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
  localparam int CHAR_W  = 8;
  localparam int LEN_W   = 5;
  localparam int ROW_W   = MAX_WORD_LEN * CHAR_W;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEXT = 1'b1;

  typedef logic [MAX_WORD_LEN-1:0][CHAR_W-1:0] row_t;

  typedef struct packed {
    logic              cmd;
    logic [3:0]        word_slot;
    logic [3:0]        char_pos;
    logic [LEN_W-1:0]  word_length;
    logic [CHAR_W-1:0] char_value;
    logic              first_char;
    logic              last_char;
  } in_req_t;

  typedef struct packed {
    logic prefix_breakable;
    logic string_done;
  } out_res_t;

  typedef struct packed {
    logic               wr_en;
    logic [SLOT_IW-1:0] wr_slot;
    logic [POS_IW-1:0]  wr_pos;
    logic [CHAR_W-1:0]  wr_data;
    logic               rd_en;
    logic [SLOT_IW-1:0] rd_slot;
  } ram_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

[src/wbs_dict_ram.sv]
// Dictionary character memory: one row per slot, byte-wide writes, registered row reads.
module wbs_dict_ram (
  input  logic              clk,
  input  wbs_pkg::ram_ctl_t ctl,
  output wbs_pkg::row_t     rd_row
);
  import wbs_pkg::*;

  row_t mem [DICT_WORDS];
  row_t rd_row_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_slot][ctl.wr_pos] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_row_r <= mem[ctl.rd_slot];
    end
  end

  assign rd_row = rd_row_r;

endmodule

[src/wbs_match.sv]
// Compares one dictionary row against the byte history and checks the prefix bit behind it.
module wbs_match (
  input  wbs_pkg::row_t                           row,
  input  wbs_pkg::row_t                           hist,
  input  logic [wbs_pkg::LEN_W-1:0]               len,
  input  logic [wbs_pkg::MAX_WORD_LEN-1:0]        brk,
  output logic                                    hit
);
  import wbs_pkg::*;

  logic              len_ok;
  logic              chars_ok;
  logic [POS_IW-1:0] idx;
  logic [POS_IW-1:0] brk_idx;

  always_comb begin
    len_ok   = (len != '0) && (int'(len) <= MAX_WORD_LEN);
    brk_idx  = POS_IW'(int'(len) - 1);
    chars_ok = 1'b1;
    idx      = '0;
    for (int j = 0; j < MAX_WORD_LEN; j++) begin
      if (j < int'(len)) begin
        idx = POS_IW'(int'(len) - 1 - j);
        if (row[j] != hist[idx]) begin
          chars_ok = 1'b0;
        end
      end
    end
    hit = len_ok && brk[brk_idx] && chars_ok;
  end

endmodule

[src/word_break_segmenter_core.sv]
// Top level of the word break segmenter: control, history, length table and result register.
//
// The in_ channel carries requests of type in_req_t. A load request (cmd low) writes one
// dictionary character and the slot's word length; it gives no result.
// A text request (cmd high) shifts one byte into the history and gives exactly one result
// on the out_ channel: prefix_breakable tells whether the text so far splits into words,
// and string_done repeats last_char. first_char starts a new string.
// A text byte's result shows on out_valid in the same cycle that in_ready returns, so
// a new text byte is taken only once the last one's result is out. The scan is paced
// by the dictionary memory, which delivers one slot's word per cycle to a single
// comparator. Load requests are taken back to back, one per cycle, while no scan runs.
// Reset clears the word length table, so every slot reads as empty, and clears the
// history and prefix bits, so no prefix is breakable until a first_char byte arrives. Dictionary
// characters are not cleared and must be written before their slot is given a length that uses them.
// The result sits in an output register. A stalled receiver does not block the next
// request; only a second result waiting behind an untaken one holds the block until
// out_ready rises.
module word_break_segmenter_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  wbs_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_ready,
  output wbs_pkg::out_res_t out_res
);
  import wbs_pkg::*;

  state_t                  state_r, state_nxt;
  logic [LEN_W-1:0]        len_r [DICT_WORDS];
  row_t                    hist_r, hist_nxt;
  logic [MAX_WORD_LEN-1:0] brk_r, brk_nxt;
  logic                    issue_r, issue_nxt;
  logic [SLOT_IW-1:0]      rd_slot_r, rd_slot_nxt;
  logic                    cmp_valid_r, cmp_valid_nxt;
  logic [SLOT_IW-1:0]      cmp_slot_r, cmp_slot_nxt;
  logic                    cmp_last_r, cmp_last_nxt;
  logic                    hit_r, hit_nxt;
  logic                    last_r, last_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_res_t                out_res_r, out_res_nxt;

  ram_ctl_t                ram_ctl;
  row_t                    rd_row;
  logic                    slot_hit;
  logic                    final_hit;
  logic                    out_free;
  logic                    accept;
  logic                    load_ok;

  wbs_dict_ram u_ram (
    .clk    (clk),
    .ctl    (ram_ctl),
    .rd_row (rd_row)
  );

  wbs_match u_match (
    .row  (rd_row),
    .hist (hist_r),
    .len  (len_r[cmp_slot_r]),
    .brk  (brk_r),
    .hit  (slot_hit)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign load_ok   = accept && (in_req.cmd == CMD_LOAD) && (int'(in_req.word_slot) < DICT_WORDS);
  assign out_free  = !out_valid_r || out_ready;
  assign final_hit = hit_r || slot_hit;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    state_nxt     = state_r;
    hist_nxt      = hist_r;
    brk_nxt       = brk_r;
    issue_nxt     = issue_r;
    rd_slot_nxt   = rd_slot_r;
    cmp_valid_nxt = 1'b0;
    cmp_slot_nxt  = cmp_slot_r;
    cmp_last_nxt  = cmp_last_r;
    hit_nxt       = hit_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_res_nxt   = out_res_r;

    ram_ctl         = '0;
    ram_ctl.wr_en   = load_ok && (int'(in_req.char_pos) < MAX_WORD_LEN);
    ram_ctl.wr_slot = SLOT_IW'(in_req.word_slot);
    ram_ctl.wr_pos  = POS_IW'(in_req.char_pos);
    ram_ctl.wr_data = in_req.char_value;
    ram_ctl.rd_slot = rd_slot_r;

    case (state_r)
      S_IDLE: begin
        if (accept && (in_req.cmd == CMD_TEXT)) begin
          if (in_req.first_char) begin
            hist_nxt    = '0;
            hist_nxt[0] = in_req.char_value;
            brk_nxt     = MAX_WORD_LEN'(1);
          end else begin
            hist_nxt = ROW_W'({hist_r, in_req.char_value});
          end
          last_nxt    = in_req.last_char;
          hit_nxt     = 1'b0;
          issue_nxt   = 1'b1;
          rd_slot_nxt = '0;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (issue_r) begin
          ram_ctl.rd_en = 1'b1;
          cmp_valid_nxt = 1'b1;
          cmp_slot_nxt  = rd_slot_r;
          cmp_last_nxt  = (rd_slot_r == SLOT_IW'(DICT_WORDS - 1));
          rd_slot_nxt   = rd_slot_r + 1'b1;
          if (rd_slot_r == SLOT_IW'(DICT_WORDS - 1)) begin
            issue_nxt = 1'b0;
          end
        end
        if (cmp_valid_r) begin
          hit_nxt = final_hit;
          if (cmp_last_r) begin
            brk_nxt = MAX_WORD_LEN'({brk_r, final_hit});
            if (out_free) begin
              out_valid_nxt                = 1'b1;
              out_res_nxt.prefix_breakable = final_hit;
              out_res_nxt.string_done      = last_r;
              state_nxt                    = S_IDLE;
            end else begin
              state_nxt = S_DONE;
            end
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt                = 1'b1;
          out_res_nxt.prefix_breakable = hit_r;
          out_res_nxt.string_done      = last_r;
          state_nxt                    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hist_r      <= '0;
      brk_r       <= '0;
      issue_r     <= 1'b0;
      rd_slot_r   <= '0;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < DICT_WORDS; i++) begin
        len_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      hist_r      <= hist_nxt;
      brk_r       <= brk_nxt;
      issue_r     <= issue_nxt;
      rd_slot_r   <= rd_slot_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (load_ok) begin
        len_r[SLOT_IW'(in_req.word_slot)] <= in_req.word_length;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_slot_r <= cmp_slot_nxt;
    cmp_last_r <= cmp_last_nxt;
    hit_r      <= hit_nxt;
    last_r     <= last_nxt;
    out_res_r  <= out_res_nxt;
  end

endmodule

[src/wbs_checker.sv]
// Port-level assertions for the word break segmenter and the bind that attaches them.
module wbs_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input wbs_pkg::in_req_t  in_req,
  input logic              out_valid,
  input logic              out_ready,
  input wbs_pkg::out_res_t out_res
);
  import wbs_pkg::*;

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_res))
    else $error("Result changed or dropped while stalled.");

  // A text request occupies the block for a dictionary scan.
  a_text_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req.cmd == CMD_TEXT) |=> !in_ready)
    else $error("Request accepted during a dictionary scan.");

  // A load request leaves the block ready for the next request.
  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req.cmd == CMD_LOAD) |=> in_ready)
    else $error("Load request did not complete in one cycle.");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid after reset.");

endmodule

bind word_break_segmenter_core wbs_checker u_wbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_res   (out_res)
);
